/* hdl/gcl_pkg.sv */
// Package for the gamma curve with linear toe block.
// Holds widths, register codes, the side-band type and the exp2 coefficient function.
// No dependencies.
package gcl_pkg;

    localparam int IN_W   = 12;
    localparam int OUT_W  = 12;
    localparam int PIX_W  = 12;
    localparam int BUS_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int FRAC   = 24;
    localparam int Z_W    = 31;
    localparam int LOG_N  = 24;
    localparam int EXP_N  = 24;
    localparam int ACC_W  = 32;
    localparam int DIV_W  = 32;
    localparam int Y_W    = 30;
    localparam int D_W    = 46;
    localparam int T_W    = 26;
    localparam int N_W    = 44;
    localparam int M_W    = N_W + OUT_W + 1;
    localparam int K_MAX  = 40;

    typedef enum logic [IDX_W-1:0] {
        REG_KINK      = 3'd0,
        REG_TOE_GAIN  = 3'd1,
        REG_TOE_OFF   = 3'd2,
        REG_CRV_GAIN  = 3'd3,
        REG_CRV_EXP   = 3'd4,
        REG_CRV_OFF   = 3'd5,
        REG_UNIT      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [IN_W-1:0] pix;
        logic            toe;
        logic            zero;
        logic            bypass;
        logic [4:0]      cnt;
        logic            saty;
        logic [6:0]      k;
        logic            neg;
        logic            satq;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int q = 0; q < 32; q++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // c_i = floor(sqrt(c_(i-1) * 2^30)), c_0 = 2^31
    function automatic logic [Z_W-1:0] exp_coef(input int idx);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 1; i <= EXP_N; i++) begin
            if (i <= idx) begin
                c = isqrt64(c << 30);
            end
        end
        return c[Z_W-1:0];
    endfunction

endpackage

/* hdl/gcl_log_cell.sv */
// One squaring step of the -log2 chain.
// Depends on gcl_pkg.
module gcl_log_cell (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [gcl_pkg::Z_W-1:0] i_z,
    input  logic [gcl_pkg::FRAC-1:0] i_frac,
    output logic [gcl_pkg::Z_W-1:0] o_z,
    output logic [gcl_pkg::FRAC-1:0] o_frac
);

    logic [2*gcl_pkg::Z_W-1:0] w_sq;
    logic [31:0]               w_sh;
    logic [gcl_pkg::Z_W-1:0]   n_z;
    logic [gcl_pkg::FRAC-1:0]  n_frac;
    logic [gcl_pkg::Z_W-1:0]   r_z;
    logic [gcl_pkg::FRAC-1:0]  r_frac;

    always_comb begin
        w_sq = i_z * i_z;
        w_sh = w_sq[61:30];
        if (w_sh[31]) begin
            n_z    = w_sh[31:1];
            n_frac = {i_frac[gcl_pkg::FRAC-2:0], 1'b1};
        end else begin
            n_z    = w_sh[30:0];
            n_frac = {i_frac[gcl_pkg::FRAC-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z    <= n_z;
            r_frac <= n_frac;
        end
    end

    assign o_z    = r_z;
    assign o_frac = r_frac;

endmodule

/* hdl/gcl_exp_cell.sv */
// One conditional multiply step of the exp2 chain.
// Depends on gcl_pkg.
module gcl_exp_cell (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [gcl_pkg::Z_W-1:0]   i_coef,
    input  logic [gcl_pkg::ACC_W-1:0] i_acc,
    input  logic [gcl_pkg::FRAC-1:0]  i_s,
    output logic [gcl_pkg::ACC_W-1:0] o_acc,
    output logic [gcl_pkg::FRAC-1:0]  o_s
);

    logic [gcl_pkg::ACC_W+gcl_pkg::Z_W-1:0] w_prod;
    logic [gcl_pkg::ACC_W-1:0]              n_acc;
    logic [gcl_pkg::ACC_W-1:0]              r_acc;
    logic [gcl_pkg::FRAC-1:0]               r_s;

    always_comb begin
        w_prod = i_acc * i_coef;
        n_acc  = i_s[gcl_pkg::FRAC-1] ? w_prod[61:30] : i_acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
            r_s   <= {i_s[gcl_pkg::FRAC-2:0], 1'b0};
        end
    end

    assign o_acc = r_acc;
    assign o_s   = r_s;

endmodule

/* hdl/gcl_div_cell.sv */
// One restoring division step by a 16-bit divisor.
// Depends on gcl_pkg.
module gcl_div_cell (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [15:0]               i_div,
    input  logic [15:0]               i_rem,
    input  logic [gcl_pkg::DIV_W-1:0] i_word,
    output logic [15:0]               o_rem,
    output logic [gcl_pkg::DIV_W-1:0] o_word
);

    logic [16:0]               w_try;
    logic                      w_q;
    logic [15:0]               n_rem;
    logic [15:0]               r_rem;
    logic [gcl_pkg::DIV_W-1:0] r_word;

    always_comb begin
        w_try = {i_rem, i_word[gcl_pkg::DIV_W-1]};
        w_q   = (w_try >= {1'b0, i_div});
        n_rem = w_q ? 16'(w_try - {1'b0, i_div}) : w_try[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_word <= {i_word[gcl_pkg::DIV_W-2:0], w_q};
        end
    end

    assign o_rem  = r_rem;
    assign o_word = r_word;

endmodule

/* hdl/gamma_curve_with_linear_toe.sv */
// Gamma curve with linear toe: top level with config registers and cell chains.
// Depends on gcl_pkg, gcl_log_cell, gcl_exp_cell, gcl_div_cell.
//
// Use: pixel words enter on the s-side stream (tdata[11:0] = pixel_in) and
// gamma-coded words leave on the m-side stream (tdata[11:0] = pixel_out).
// Seven 16-bit registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata;
// the user must write them only while no word is in flight, and the block
// does not enforce it. Throughput: one word per clock while the receiver
// takes output words. Every stage advances together; the chains are 24
// squaring cells (log2), 30 divide cells (exponent scaling), 24 multiply
// cells (exp2) and OUT_WIDTH divide cells (final scaling).
// Reset: registers take their default curve, the pipeline and output
// empty, and the input side is ready.
// Stall: an output register plus one skid word sit behind the pipeline.
// When the receiver holds off, the next word lands in the skid register
// and the input side drops ready until the output is taken.
module gamma_curve_with_linear_toe (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [gcl_pkg::BUS_W-1:0]       i_s_tdata,   // [11:0] pixel_in
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [gcl_pkg::BUS_W-1:0]       o_m_tdata,   // [11:0] pixel_out
    input  logic                            i_cfg_we,
    input  logic [gcl_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [gcl_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int ST_D   = gcl_pkg::LOG_N + 1;
    localparam int ST_Y0  = ST_D + 1;
    localparam int ST_E0  = ST_Y0 + gcl_pkg::Y_W + 1;
    localparam int ST_T   = ST_E0 + gcl_pkg::EXP_N + 1;
    localparam int ST_N   = ST_T + 1;
    localparam int ST_M   = ST_N + 1;
    localparam int ST_F   = ST_M + gcl_pkg::OUT_W + 1;
    localparam int QHI_W  = gcl_pkg::M_W - gcl_pkg::FRAC - gcl_pkg::OUT_W;
    localparam int QLO    = gcl_pkg::FRAC + gcl_pkg::OUT_W;

    localparam logic [15:0] IN_MAX  = 16'((1 << gcl_pkg::IN_W) - 1);
    localparam logic [gcl_pkg::OUT_W-1:0] OUT_MAX = {gcl_pkg::OUT_W{1'b1}};

    // config registers
    logic [15:0]        r_kink, r_toe_gain, r_crv_gain, r_exp, r_unit;
    logic signed [15:0] r_toe_off, r_crv_off;
    logic [15:0]        w_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kink     <= 16'd18;
            r_toe_gain <= 16'd4500;
            r_toe_off  <= 16'sd0;
            r_crv_gain <= 16'd1099;
            r_exp      <= 16'd450;
            r_crv_off  <= -16'sd99;
            r_unit     <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gcl_pkg::REG_KINK:     r_kink     <= i_cfg_wdata;
                gcl_pkg::REG_TOE_GAIN: r_toe_gain <= i_cfg_wdata;
                gcl_pkg::REG_TOE_OFF:  r_toe_off  <= $signed(i_cfg_wdata);
                gcl_pkg::REG_CRV_GAIN: r_crv_gain <= i_cfg_wdata;
                gcl_pkg::REG_CRV_EXP:  r_exp      <= i_cfg_wdata;
                gcl_pkg::REG_CRV_OFF:  r_crv_off  <= $signed(i_cfg_wdata);
                gcl_pkg::REG_UNIT:     r_unit     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_u = (r_unit == 16'd0) ? 16'd1 : r_unit;

    // flow control
    logic w_en;
    logic r_skid_v, r_out_v;
    logic [gcl_pkg::PIX_W-1:0] r_skid, r_out;
    logic w_take;

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;
    assign w_take     = r_out_v && i_m_tready;

    // valid and side-band lines
    logic          r_valid [0:ST_F];
    gcl_pkg::t_side r_side [0:ST_F];
    gcl_pkg::t_side n_side [0:ST_F];

    // input stage
    logic [15:0]              w_pix16;
    logic [gcl_pkg::IN_W-1:0] w_pix;
    logic [31:0]              w_pu, w_kink_sh;
    logic [gcl_pkg::FRAC-1:0] w_x24;
    logic [4:0]               w_lead;
    logic [54:0]              w_zsh;
    logic [gcl_pkg::Z_W-1:0]  r_z0;

    always_comb begin
        w_pix16 = {4'b0, i_s_tdata[gcl_pkg::PIX_W-1:0]};
        if (w_pix16 > IN_MAX) begin
            w_pix16 = IN_MAX;
        end
        w_pix     = w_pix16[gcl_pkg::IN_W-1:0];
        w_pu      = 32'(w_pix) * 32'(w_u);
        w_kink_sh = 32'(r_kink) << gcl_pkg::IN_W;
        w_x24     = gcl_pkg::FRAC'(w_pix) << (gcl_pkg::FRAC - gcl_pkg::IN_W);
        w_lead    = 5'd0;
        for (int b = 0; b < gcl_pkg::FRAC; b++) begin
            if (w_x24[b]) begin
                w_lead = 5'(b);
            end
        end
        w_zsh = 55'(w_x24) << (5'd30 - w_lead);
    end

    // log chain
    logic [gcl_pkg::Z_W-1:0]  w_z    [0:gcl_pkg::LOG_N];
    logic [gcl_pkg::FRAC-1:0] w_frac [0:gcl_pkg::LOG_N];

    assign w_z[0]    = r_z0;
    assign w_frac[0] = '0;

    for (genvar j = 0; j < gcl_pkg::LOG_N; j++) begin : g_log
        gcl_log_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_z    (w_z[j]),
            .i_frac (w_frac[j]),
            .o_z    (w_z[j+1]),
            .o_frac (w_frac[j+1])
        );
    end

    // exponent scaling: y = (L*e + u/2) / u
    logic [28:0]             w_l;
    logic [44:0]             w_le;
    logic [gcl_pkg::D_W-1:0] r_d;
    logic [15:0]             r_yrem0;
    logic [gcl_pkg::DIV_W-1:0] r_yword0;
    logic                    w_saty;

    always_comb begin
        w_l    = {r_side[gcl_pkg::LOG_N].cnt, 24'd0} - 29'(w_frac[gcl_pkg::LOG_N]);
        w_le   = w_l * r_exp;
        w_saty = (r_d[gcl_pkg::D_W-1:gcl_pkg::Y_W] >= w_u);
    end

    logic [15:0]               w_yrem  [0:gcl_pkg::Y_W];
    logic [gcl_pkg::DIV_W-1:0] w_yword [0:gcl_pkg::Y_W];

    assign w_yrem[0]  = r_yrem0;
    assign w_yword[0] = r_yword0;

    for (genvar j = 0; j < gcl_pkg::Y_W; j++) begin : g_ydiv
        gcl_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_div  (w_u),
            .i_rem  (w_yrem[j]),
            .i_word (w_yword[j]),
            .o_rem  (w_yrem[j+1]),
            .o_word (w_yword[j+1])
        );
    end

    // exp2 chain
    logic [gcl_pkg::Y_W-1:0]  w_y;
    logic [gcl_pkg::FRAC-1:0] w_s;
    logic [30:0]              w_ys;
    logic [gcl_pkg::FRAC-1:0] r_s0;

    always_comb begin
        w_y  = w_yword[gcl_pkg::Y_W][gcl_pkg::Y_W-1:0];
        w_s  = gcl_pkg::FRAC'(~w_y + 1'b1);
        w_ys = 31'(w_y) + 31'(w_s);
    end

    logic [gcl_pkg::ACC_W-1:0] w_acc [0:gcl_pkg::EXP_N];
    logic [gcl_pkg::FRAC-1:0]  w_sx  [0:gcl_pkg::EXP_N];

    assign w_acc[0] = gcl_pkg::ACC_W'(1) << 30;
    assign w_sx[0]  = r_s0;

    for (genvar j = 0; j < gcl_pkg::EXP_N; j++) begin : g_exp
        localparam logic [gcl_pkg::Z_W-1:0] COEF = gcl_pkg::exp_coef(j + 1);
        gcl_exp_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_coef (COEF),
            .i_acc  (w_acc[j]),
            .i_s    (w_sx[j]),
            .o_acc  (w_acc[j+1]),
            .o_s    (w_sx[j+1])
        );
    end

    // power term select
    gcl_pkg::t_side            w_st;
    logic [47:0]               w_rsum;
    logic [47:0]               w_rsh;
    logic [gcl_pkg::FRAC-1:0]  w_xt;
    logic [gcl_pkg::T_W-1:0]   n_t, r_t;

    always_comb begin
        w_st   = r_side[ST_T-1];
        w_rsum = 48'(w_acc[gcl_pkg::EXP_N]) + (48'd1 << (w_st.k + 7'd5));
        w_rsh  = w_rsum >> (w_st.k + 7'd6);
        w_xt   = gcl_pkg::FRAC'(w_st.pix) << (gcl_pkg::FRAC - gcl_pkg::IN_W);
        if (w_st.toe || w_st.bypass) begin
            n_t = gcl_pkg::T_W'(w_xt);
        end else if (w_st.zero) begin
            n_t = (r_exp == 16'd0) ? (gcl_pkg::T_W'(1) << gcl_pkg::FRAC) : '0;
        end else if (w_st.saty || (w_st.k > 7'(gcl_pkg::K_MAX))) begin
            n_t = '0;
        end else begin
            n_t = w_rsh[gcl_pkg::T_W-1:0];
        end
    end

    // gain and offset
    logic [15:0]                    w_gain;
    logic signed [15:0]             w_off;
    logic [41:0]                    w_gt;
    logic signed [gcl_pkg::N_W-1:0] w_offs;
    logic signed [gcl_pkg::N_W-1:0] r_n;

    always_comb begin
        w_gain = r_side[ST_N-1].toe ? r_toe_gain : r_crv_gain;
        w_off  = r_side[ST_N-1].toe ? r_toe_off : r_crv_off;
        w_gt   = w_gain * r_t;
        w_offs = gcl_pkg::N_W'(w_off);
    end

    // rounding numerator, saturation, final divide setup
    logic signed [gcl_pkg::M_W-1:0] w_m;
    logic                           w_neg, w_satq;
    logic [15:0]                    r_mrem0;
    logic [gcl_pkg::DIV_W-1:0]      r_mword0;

    always_comb begin
        w_m    = (gcl_pkg::M_W'(r_n) <<< gcl_pkg::OUT_W)
               + $signed(gcl_pkg::M_W'({w_u, 23'd0}));
        w_neg  = w_m[gcl_pkg::M_W-1];
        w_satq = (w_m[gcl_pkg::M_W-1:QLO] >= QHI_W'(w_u));
    end

    logic [15:0]               w_orem  [0:gcl_pkg::OUT_W];
    logic [gcl_pkg::DIV_W-1:0] w_oword [0:gcl_pkg::OUT_W];

    assign w_orem[0]  = r_mrem0;
    assign w_oword[0] = r_mword0;

    for (genvar j = 0; j < gcl_pkg::OUT_W; j++) begin : g_odiv
        gcl_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_div  (w_u),
            .i_rem  (w_orem[j]),
            .i_word (w_oword[j]),
            .o_rem  (w_orem[j+1]),
            .o_word (w_oword[j+1])
        );
    end

    logic [gcl_pkg::OUT_W-1:0] n_res, r_res;
    gcl_pkg::t_side            w_sf;

    always_comb begin
        w_sf = r_side[ST_F-1];
        if (w_sf.neg) begin
            n_res = '0;
        end else if (w_sf.satq) begin
            n_res = OUT_MAX;
        end else begin
            n_res = w_oword[gcl_pkg::OUT_W][gcl_pkg::OUT_W-1:0];
        end
    end

    // side-band next values
    always_comb begin
        n_side[0]        = '0;
        n_side[0].pix    = w_pix;
        n_side[0].toe    = (w_pu < w_kink_sh);
        n_side[0].zero   = (w_pix == '0);
        n_side[0].bypass = (r_exp == w_u);
        n_side[0].cnt    = 5'd24 - w_lead;
        for (int k = 1; k <= ST_F; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[ST_Y0].saty = w_saty;
        n_side[ST_E0].k    = w_ys[30:24];
        n_side[ST_M].neg   = w_neg;
        n_side[ST_M].satq  = w_satq;
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ST_F; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_valid[0] <= i_s_tvalid;
            for (int k = 1; k <= ST_F; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= ST_F; k++) begin
                r_side[k] <= n_side[k];
            end
            r_z0     <= w_zsh[gcl_pkg::Z_W-1:0];
            r_d      <= gcl_pkg::D_W'(w_le) + gcl_pkg::D_W'(w_u >> 1);
            r_yrem0  <= r_d[gcl_pkg::D_W-1:gcl_pkg::Y_W];
            r_yword0 <= {r_d[gcl_pkg::Y_W-1:0], 2'b00};
            r_s0     <= w_s;
            r_t      <= n_t;
            r_n      <= $signed({2'b00, w_gt}) + (w_offs <<< gcl_pkg::FRAC);
            r_mrem0  <= w_m[QLO+15:QLO];
            r_mword0 <= gcl_pkg::DIV_W'(w_m[QLO-1:gcl_pkg::FRAC])
                        << (gcl_pkg::DIV_W - gcl_pkg::OUT_W);
            r_res    <= n_res;
        end
    end

    // output register and skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!r_out_v || w_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            r_out_v <= r_valid[ST_F];
        end else if (r_valid[ST_F]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!r_out_v || w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || w_take) begin
            r_out <= gcl_pkg::PIX_W'(r_res);
        end else begin
            r_skid <= gcl_pkg::PIX_W'(r_res);
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = gcl_pkg::BUS_W'(r_out);

endmodule

/* hdl/gcl_checker.sv */
// Port-level checks for the gamma curve with linear toe block.
// Bound to gamma_curve_with_linear_toe; no package dependency.
module gcl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled word changed");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> $past(o_m_tvalid && !i_m_tready))
        else $error("input ready dropped without output stall");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15:12] == 4'd0)
        else $error("output padding not zero");

endmodule

bind gamma_curve_with_linear_toe gcl_checker u_gcl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
